>>> src/ctt_pkg.sv
`timescale 1ns / 1ps

package ctt_pkg;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [6:0]  SEC_LIMIT   = 7'd60;
  localparam logic [6:0]  MIN_LIMIT   = 7'd60;
  localparam logic [5:0]  HOUR_LIMIT  = 6'd24;
  localparam logic [3:0]  WDAY_LIMIT  = 4'd7;
  localparam logic [4:0]  MONTH_LIMIT = 5'd13;
  localparam logic [14:0] YEAR_MAX    = 15'd9999;

  localparam logic [4:0]  DAY_FIRST   = 5'd1;
  localparam logic [3:0]  MONTH_FIRST = 4'd1;
  localparam logic [13:0] YEAR_RESET  = 14'd2000;

  localparam logic [3:0]  MONTH_FEB = 4'd2;
  localparam logic [3:0]  MONTH_APR = 4'd4;
  localparam logic [3:0]  MONTH_JUN = 4'd6;
  localparam logic [3:0]  MONTH_SEP = 4'd9;
  localparam logic [3:0]  MONTH_NOV = 4'd11;

  // multiplicative inverse of 25 modulo 2**14, and floor((2**14 - 1) / 25)
  localparam logic [13:0] INV25     = 14'd7209;
  localparam logic [13:0] DIV25_MAX = 14'd655;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } ctt_op_t;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ctt_time_t;

  typedef struct packed {
    logic day;
    logic minute;
  } ctt_carry_t;

  // divisible by 25 through the inverse test; leap when divisible by 4 and
  // either not by 100 or also by 400 (16 and 25)
  function automatic logic is_leap(input logic [13:0] y);
    logic [13:0] prod;
    logic        div25;
    prod  = y * INV25;
    div25 = (prod <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      MONTH_FEB: len = leap ? 5'd29 : 5'd28;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

>>> src/ctt_calc.sv
`timescale 1ns / 1ps

module ctt_calc (
  input  ctt_pkg::ctt_op_t   op,
  input  ctt_pkg::ctt_time_t cur,
  input  ctt_pkg::ctt_time_t load,
  output ctt_pkg::ctt_time_t nxt,
  output ctt_pkg::ctt_carry_t carry
);

  logic [6:0]  sec_inc;
  logic [6:0]  min_inc;
  logic [5:0]  hour_inc;
  logic [3:0]  wday_inc;
  logic [5:0]  day_inc;
  logic [4:0]  month_inc;
  logic [14:0] year_inc;
  logic [4:0]  month_len;

  assign sec_inc   = {1'b0, cur.second} + 7'd1;
  assign min_inc   = {1'b0, cur.minute} + 7'd1;
  assign hour_inc  = {1'b0, cur.hour} + 6'd1;
  assign wday_inc  = {1'b0, cur.weekday} + 4'd1;
  assign day_inc   = {1'b0, cur.day} + 6'd1;
  assign month_inc = {1'b0, cur.month} + 5'd1;
  assign year_inc  = {1'b0, cur.year} + 15'd1;
  assign month_len = ctt_pkg::month_days(cur.month, ctt_pkg::is_leap(cur.year));

  always_comb begin
    nxt   = cur;
    carry = '0;
    if (op == ctt_pkg::OP_LOAD) begin
      nxt = load;
    end else if (sec_inc < ctt_pkg::SEC_LIMIT) begin
      nxt.second = sec_inc[5:0];
    end else begin
      nxt.second   = '0;
      carry.minute = 1'b1;
      if (min_inc < ctt_pkg::MIN_LIMIT) begin
        nxt.minute = min_inc[5:0];
      end else begin
        nxt.minute = '0;
        if (hour_inc < ctt_pkg::HOUR_LIMIT) begin
          nxt.hour = hour_inc[4:0];
        end else begin
          nxt.hour  = '0;
          carry.day = 1'b1;
          if (wday_inc < ctt_pkg::WDAY_LIMIT) begin
            nxt.weekday = wday_inc[2:0];
          end else begin
            nxt.weekday = 3'(wday_inc - ctt_pkg::WDAY_LIMIT);
          end
          if (day_inc <= {1'b0, month_len}) begin
            nxt.day = day_inc[4:0];
          end else begin
            nxt.day = ctt_pkg::DAY_FIRST;
            if (month_inc < ctt_pkg::MONTH_LIMIT) begin
              nxt.month = month_inc[3:0];
            end else begin
              nxt.month = ctt_pkg::MONTH_FIRST;
              if (year_inc <= ctt_pkg::YEAR_MAX) begin
                nxt.year = year_inc[13:0];
              end else begin
                nxt.year = '0;
              end
            end
          end
        end
      end
    end
  end

endmodule

>>> src/calendar_time_tick_core.sv
`timescale 1ns / 1ps

// channel | dir | tuser       | tdata
// in_     | in  | [0] op      | [5:0] sec, [11:6] min, [16:12] hour, [19:17] wday,
//         |     |             | [24:20] day, [28:25] month, [42:29] year, rest 0
// out_    | out | none        | [5:0] sec, [11:6] min, [16:12] hour, [19:17] wday,
//         |     |             | [24:20] day, [28:25] month, [42:29] year,
//         |     |             | [43] minute_carry, [44] day_carry, rest 0
//
// One beat per cycle sustained while the output is not stalled.
// Path: input register, one pass of calendar carry logic, result register.
// Reset: time goes to 00:00:00, weekday 0, day 1, month 1, year 2000; both stages empty.
// A stalled output holds its beat; the input stage still takes one more beat.

module calendar_time_tick_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ctt_pkg::IN_DATA_W-1:0]     in_tdata,   // load fields, see table
  input  logic [0:0]                        in_tuser,   // [0] op
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ctt_pkg::OUT_DATA_W-1:0]    out_tdata   // time and carries, see table
);

  logic                in_valid_r;
  ctt_pkg::ctt_op_t    in_op_r;
  ctt_pkg::ctt_time_t  in_load_r;
  ctt_pkg::ctt_time_t  in_load;
  ctt_pkg::ctt_time_t  time_r;
  ctt_pkg::ctt_time_t  time_nxt;
  ctt_pkg::ctt_carry_t carry_nxt;
  logic                out_valid_r;
  ctt_pkg::ctt_time_t  out_time_r;
  ctt_pkg::ctt_carry_t out_carry_r;
  logic                advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    in_load.second  = in_tdata[5:0];
    in_load.minute  = in_tdata[11:6];
    in_load.hour    = in_tdata[16:12];
    in_load.weekday = in_tdata[19:17];
    in_load.day     = in_tdata[24:20];
    in_load.month   = in_tdata[28:25];
    in_load.year    = in_tdata[42:29];
  end

  ctt_calc u_calc (
    .op    (in_op_r),
    .cur   (time_r),
    .load  (in_load_r),
    .nxt   (time_nxt),
    .carry (carry_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tvalid && in_tready) begin
      in_op_r   <= ctt_pkg::ctt_op_t'(in_tuser[0]);
      in_load_r <= in_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r.second  <= '0;
      time_r.minute  <= '0;
      time_r.hour    <= '0;
      time_r.weekday <= '0;
      time_r.day     <= ctt_pkg::DAY_FIRST;
      time_r.month   <= ctt_pkg::MONTH_FIRST;
      time_r.year    <= ctt_pkg::YEAR_RESET;
      out_valid_r    <= 1'b0;
    end else begin
      if (advance) begin
        time_r      <= time_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (advance) begin
      out_time_r  <= time_nxt;
      out_carry_r <= carry_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_carry_r.day, out_carry_r.minute, out_time_r.year,
                       out_time_r.month, out_time_r.day, out_time_r.weekday,
                       out_time_r.hour, out_time_r.minute, out_time_r.second};

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid_r && !in_valid_r)
    else $error("stages not empty after reset");

  a_out_tracks_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_time_r == time_r)
    else $error("result beat differs from calendar state");

  a_minute_carry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_carry_r.minute |-> out_time_r.second == '0)
    else $error("minute carry without second rollover");

  a_day_carry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_carry_r.day |->
      out_carry_r.minute && out_time_r.minute == '0 && out_time_r.hour == '0)
    else $error("day carry without midnight");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> in_valid_r && out_valid_r && !out_tready)
    else $error("input stalled with room downstream");

endmodule

>>> dv/tb_calendar_time_tick_core.sv
`timescale 1ns / 1ps

module tb_calendar_time_tick_core;
  import ctt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned HOLD_CYCLES = 60;

  typedef struct packed {
    ctt_carry_t carry;
    ctt_time_t  t;
  } cal_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;   // sec, min, hour, wday, day, month, year
  logic [0:0]            in_tuser   = '0;   // [0] op
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;         // sec .. year, minute_carry, day_carry

  cal_result_t pending_results[$];
  ctt_time_t   cal_now;
  int unsigned err_cnt      = 0;
  int unsigned cycle_cnt    = 0;
  bit          src_idle_en  = 1'b0;
  bit          sink_idle_en = 1'b0;
  int unsigned hold_req     = 0;
  int unsigned hold_seen    = 0;
  int unsigned sink_wait    = 0;

  calendar_time_tick_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  function automatic bit leap_year(input logic [13:0] y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  function automatic int month_length(input logic [3:0] m, input logic [13:0] y);
    if (m == MONTH_FEB) return leap_year(y) ? 29 : 28;
    case (m)
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: return 30;
      default: return 31;
    endcase
  endfunction

  function automatic cal_result_t step_calendar(input ctt_op_t op, input ctt_time_t ld);
    cal_result_t r;
    int s, mi, h, d, mo, y;
    r.carry = '0;
    if (op == OP_LOAD) begin
      cal_now = ld;
    end else begin
      s = cal_now.second + 1;
      if (s >= SEC_LIMIT) begin
        s = 0;
        r.carry.minute = 1'b1;
        mi = cal_now.minute + 1;
        if (mi >= MIN_LIMIT) begin
          mi = 0;
          h = cal_now.hour + 1;
          if (h >= HOUR_LIMIT) begin
            h = 0;
            r.carry.day = 1'b1;
            cal_now.weekday = 3'((cal_now.weekday + 1) % WDAY_LIMIT);
            d = cal_now.day + 1;
            if (d > month_length(cal_now.month, cal_now.year)) begin
              d = 1;
              mo = cal_now.month + 1;
              if (mo >= MONTH_LIMIT) begin
                mo = 1;
                y = cal_now.year + 1;
                if (y > YEAR_MAX) y = 0;
                cal_now.year = 14'(y);
              end
              cal_now.month = 4'(mo);
            end
            cal_now.day = 5'(d);
          end
          cal_now.hour = 5'(h);
        end
        cal_now.minute = 6'(mi);
      end
      cal_now.second = 6'(s);
    end
    r.t = cal_now;
    return r;
  endfunction

  function automatic ctt_time_t mk_time(input int s, input int mi, input int h, input int w,
                                        input int d, input int mo, input int y);
    ctt_time_t t;
    t.second  = 6'(s);
    t.minute  = 6'(mi);
    t.hour    = 5'(h);
    t.weekday = 3'(w);
    t.day     = 5'(d);
    t.month   = 4'(mo);
    t.year    = 14'(y);
    return t;
  endfunction

  function automatic ctt_time_t rand_fields();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[$bits(ctt_time_t)-1:0];
  endfunction

  function automatic ctt_time_t near_rollover();
    ctt_time_t t;
    int        y, mo, len;
    case ($urandom_range(0, 3))
      0: y = $urandom_range(0, 9999);
      1: y = 9999;
      2: y = 100 * $urandom_range(0, 99);
      default: y = 4 * $urandom_range(0, 2499);
    endcase
    mo  = ($urandom_range(0, 3) == 0) ? 12 : $urandom_range(1, 12);
    len = month_length(4'(mo), 14'(y));
    t = mk_time($urandom_range(50, 59),
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 59) : 59,
                ($urandom_range(0, 3) == 0) ? $urandom_range(0, 23) : 23,
                $urandom_range(0, 6),
                ($urandom_range(0, 2) == 0) ? $urandom_range(1, len) : len,
                mo, y);
    return t;
  endfunction

  task automatic send_beat(input ctt_op_t op, input ctt_time_t fields);
    int gap;
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 10);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_DATA_W'(fields);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(step_calendar(op, fields));
  endtask

  task automatic wait_results_done();
    int unsigned n;
    n = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
  endtask

  task automatic compare_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch exp %0d got %0d", $time, name, want_v, got_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      sink_wait  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait  <= sink_wait - 1;
      out_tready <= 1'b0;
    end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
      sink_wait  <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    cal_result_t want;
    ctt_time_t   got_t;
    ctt_carry_t  got_c;
    if (rst_n && out_tvalid && out_tready) begin
      got_t = out_tdata[$bits(ctt_time_t)-1:0];
      got_c = out_tdata[$bits(ctt_time_t)+1:$bits(ctt_time_t)];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat exp none got %h", $time, out_tdata);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        compare_field("second", want.t.second, got_t.second);
        compare_field("minute", want.t.minute, got_t.minute);
        compare_field("hour", want.t.hour, got_t.hour);
        compare_field("weekday", want.t.weekday, got_t.weekday);
        compare_field("day", want.t.day, got_t.day);
        compare_field("month", want.t.month, got_t.month);
        compare_field("year", want.t.year, got_t.year);
        compare_field("minute_carry", want.carry.minute, got_c.minute);
        compare_field("day_carry", want.carry.day, got_c.day);
        compare_field("pad", 0, out_tdata[OUT_DATA_W-1:$bits(ctt_time_t)+2]);
      end
    end
  end

  task automatic test_directed();
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(0, 0, 0, 0, 0, 0, 0));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(63, 63, 31, 7, 31, 15, 16383));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(59, 59, 23, 6, 31, 12, 9999));
    send_beat(OP_TICK, '0);
    // day zero in month zero
    send_beat(OP_LOAD, mk_time(59, 59, 23, 2, 0, 0, 2023));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(59, 59, 23, 3, 31, 0, 2023));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(59, 59, 23, 4, 28, 2, 1900));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(59, 59, 23, 5, 28, 2, 2000));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(59, 59, 23, 6, 29, 2, 2000));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(59, 59, 23, 7, 30, 4, 2021));
    send_beat(OP_TICK, '0);
    send_beat(OP_LOAD, mk_time(59, 34, 12, 1, 15, 7, 1999));
    send_beat(OP_TICK, rand_fields());
  endtask

  task automatic test_rollover_runs(input int n_items);
    int sent, ticks;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) != 0) begin
        send_beat(OP_LOAD, near_rollover());
        sent++;
      end
      ticks = $urandom_range(1, 8);
      repeat (ticks) send_beat(OP_TICK, rand_fields());
      sent += ticks;
    end
  endtask

  task automatic test_field_noise(input int n_items);
    ctt_time_t t;
    int        sent, ticks;
    sent = 0;
    while (sent < n_items) begin
      t = rand_fields();
      if ($urandom_range(0, 1) == 0) begin
        t.second = 6'($urandom_range(59, 63));
        t.minute = 6'($urandom_range(59, 63));
        t.hour   = 5'($urandom_range(23, 31));
      end
      send_beat(OP_LOAD, t);
      ticks = $urandom_range(0, 3);
      repeat (ticks) send_beat(OP_TICK, rand_fields());
      sent += ticks + 1;
    end
  endtask

  task automatic test_backpressure();
    src_idle_en = 1'b0;
    hold_req <= hold_req + 1;
    test_rollover_runs(40);
    src_idle_en = 1'b1;
  endtask

  task automatic test_pause_drain();
    test_rollover_runs(20);
    wait_results_done();
    test_rollover_runs(20);
  endtask

  initial begin
    cal_now = mk_time(0, 0, 0, 0, DAY_FIRST, MONTH_FIRST, YEAR_RESET);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    wait_results_done();

    src_idle_en = 1'b1;
    sink_idle_en <= 1'b1;
    test_rollover_runs(1300);
    test_backpressure();
    test_pause_drain();
    test_field_noise(300);

    src_idle_en = 1'b0;
    sink_idle_en <= 1'b0;
    test_rollover_runs(300);

    wait_results_done();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: results missing exp %0d got 0", $time, pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
